[rtl/annexb_nal_unit_splitter_macros.svh]
// assertion macros for the annex-b nal unit splitter
// no dependencies; included by the rtl files that check their own logic
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, quiet during reset
`define ANX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, quiet during reset
`define ANX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ANX_ASSERT_IMP(label, ante, cons, msg)
`define ANX_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[rtl/anx_nal_pkg.sv]
// types and constants for the annex-b nal unit splitter
// no dependencies; used by the top level and by whoever instantiates the channels
`default_nettype none

package anx_nal_pkg;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // header field masks
  localparam logic [7:0] AVC_MASK  = 8'h1f;
  localparam logic [7:0] HEVC_MASK = 8'h3f;

  // start code marker byte
  localparam logic [7:0] START_MARK = 8'h01;

  // input word
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       flush;
  } anx_in_t;

  // result word
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] zeros_before;
    logic        first_of_nal;
    logic [4:0]  avc_nal_type;
    logic [5:0]  hevc_nal_type;
    logic [23:0] nal_length;
    logic        final_nal;
    logic        count_saturated;
  } anx_out_t;

endpackage

`default_nettype wire

[rtl/anx_stream_if.sv]
// valid/ready channel carrying one word of a chosen payload type
// no dependencies; the payload type is given at instantiation
`default_nettype none

interface anx_stream_if #(
  parameter type payload_t = logic [7:0]
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

`default_nettype wire

[rtl/annexb_nal_unit_splitter.sv]
// Annex-B NAL unit splitter: one stream byte per word in, payload and end-of-NAL words out.
// Channels are anx_stream_if instances: in_chan carries anx_nal_pkg::anx_in_t,
// out_chan carries anx_nal_pkg::anx_out_t. Assertions use the macros header.
//
// Usage:
//  - in_chan takes one stream byte per word, or a flush word that ends the buffer.
//  - out_chan gives at most one result word per input word: a released payload
//    byte with its held zeros and NAL types, or an end word with the NAL length.
//  - a taken word's result is registered in the output register, or in the skid register while a result waits.
//  - throughput is one word per cycle, sustained while out_chan is being drained;
//    the whole per-byte rule sits between the input handshake and the output register.
//  - the output has a two-word buffer (output register plus skid register), so a
//    word is still taken while one result waits; in_chan.ready falls only when both
//    are full and comes back the cycle after out_chan takes a word.
//  - a word that gives no result (held zero, dropped byte, empty NAL) is taken
//    whenever in_chan.ready is high.
//  - synchronous active-low reset clears the parser state and empties the buffer;
//    the block is ready in the first cycle after reset, with no clearing pass.
//  - a flush closes any open non-empty NAL and returns the parser to its reset state.
`include "annexb_nal_unit_splitter_macros.svh"
`default_nettype none

module annexb_nal_unit_splitter #(
  parameter int ZERO_COUNT_BITS = 16,
  parameter int LENGTH_BITS     = 24
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  anx_stream_if.sink   in_chan,
  anx_stream_if.source out_chan
);

  import anx_nal_pkg::*;

  localparam int SUM_BITS =
    ((LENGTH_BITS > ZERO_COUNT_BITS) ? LENGTH_BITS : ZERO_COUNT_BITS) + 2;
  localparam logic [ZERO_COUNT_BITS-1:0] ZERO_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]     LEN_MAX  = '1;

  // parser state
  logic [ZERO_COUNT_BITS-1:0] held_zero_count_r, held_zero_count_nxt;
  logic                       inside_nal_r, inside_nal_nxt;
  logic                       nal_has_bytes_r, nal_has_bytes_nxt;
  logic [LENGTH_BITS-1:0]     bytes_in_nal_r, bytes_in_nal_nxt;
  logic [7:0]                 header_value_r, header_value_nxt;
  logic                       saturation_seen_r, saturation_seen_nxt;

  // output buffer
  logic     out_valid_r, out_valid_nxt;
  anx_out_t out_data_r, out_data_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  anx_out_t skid_data_r, skid_data_nxt;

  logic       in_fire;
  logic [7:0] in_byte;
  logic       in_flush;
  logic       res_valid;
  anx_out_t   res;
  anx_out_t   close_res;
  logic       close_ok;
  logic       first_rel;
  logic [SUM_BITS-1:0] len_sum;
  logic [LENGTH_BITS-1:0] len_sat;
  logic       len_hit;

  assign in_byte  = in_chan.payload.stream_byte;
  assign in_flush = in_chan.payload.flush;
  assign in_chan.ready = !skid_valid_r;
  assign in_fire  = in_chan.valid && in_chan.ready;

  // end-of-nal word built from the current state
  always_comb begin
    close_ok                  = inside_nal_r && nal_has_bytes_r;
    close_res                 = '0;
    close_res.kind            = KIND_END;
    close_res.avc_nal_type    = 5'(header_value_r & AVC_MASK);
    close_res.hevc_nal_type   = (bytes_in_nal_r > LENGTH_BITS'(1)) ?
                                6'((header_value_r >> 1) & HEVC_MASK) : 6'd0;
    close_res.nal_length      = 24'(bytes_in_nal_r);
    close_res.count_saturated = saturation_seen_r;
  end

  // running length with saturation
  always_comb begin
    len_sum   = SUM_BITS'(bytes_in_nal_r) + SUM_BITS'(held_zero_count_r) + SUM_BITS'(1);
    len_hit   = (len_sum >= SUM_BITS'(LEN_MAX));
    len_sat   = len_hit ? LEN_MAX : len_sum[LENGTH_BITS-1:0];
    first_rel = !nal_has_bytes_r;
  end

  // per-byte parser rule
  always_comb begin
    held_zero_count_nxt = held_zero_count_r;
    inside_nal_nxt      = inside_nal_r;
    nal_has_bytes_nxt   = nal_has_bytes_r;
    bytes_in_nal_nxt    = bytes_in_nal_r;
    header_value_nxt    = header_value_r;
    saturation_seen_nxt = saturation_seen_r;
    res_valid           = 1'b0;
    res                 = '0;
    if (in_fire) begin
      if (in_flush) begin
        // close and return to reset state
        res_valid           = close_ok;
        res                 = close_res;
        res.final_nal       = 1'b1;
        held_zero_count_nxt = '0;
        inside_nal_nxt      = 1'b0;
        nal_has_bytes_nxt   = 1'b0;
        bytes_in_nal_nxt    = '0;
        header_value_nxt    = '0;
        saturation_seen_nxt = 1'b0;
      end else if (in_byte == 8'd0) begin
        // hold the zero back
        if (held_zero_count_r != ZERO_MAX) begin
          held_zero_count_nxt = held_zero_count_r + ZERO_COUNT_BITS'(1);
        end
        if (held_zero_count_nxt == ZERO_MAX) begin
          saturation_seen_nxt = 1'b1;
        end
      end else if (in_byte == START_MARK && held_zero_count_r >= ZERO_COUNT_BITS'(2)) begin
        // start code: close the open nal, open a fresh one
        res_valid           = close_ok;
        res                 = close_res;
        res.final_nal       = 1'b0;
        held_zero_count_nxt = '0;
        inside_nal_nxt      = 1'b1;
        nal_has_bytes_nxt   = 1'b0;
        bytes_in_nal_nxt    = '0;
        header_value_nxt    = '0;
        saturation_seen_nxt = 1'b0;
      end else if (!inside_nal_r) begin
        // leading junk before the first start code
        held_zero_count_nxt = '0;
      end else begin
        // release the byte with its held zeros
        if (first_rel) begin
          header_value_nxt = (held_zero_count_r != '0) ? 8'd0 : in_byte;
        end
        if (len_hit) begin
          saturation_seen_nxt = 1'b1;
        end
        bytes_in_nal_nxt    = len_sat;
        nal_has_bytes_nxt   = 1'b1;
        held_zero_count_nxt = '0;
        res_valid           = 1'b1;
        res.kind            = KIND_PAYLOAD;
        res.payload_byte    = in_byte;
        res.zeros_before    = 16'(held_zero_count_r);
        res.first_of_nal    = first_rel;
        res.avc_nal_type    = 5'(header_value_nxt & AVC_MASK);
        res.hevc_nal_type   = 6'((header_value_nxt >> 1) & HEVC_MASK);
        res.nal_length      = 24'(len_sat);
        res.final_nal       = 1'b0;
        res.count_saturated = saturation_seen_nxt;
      end
    end
  end

  // two-word output buffer, oldest word in the output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res_valid;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt  = res_valid;
        out_data_nxt   = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

  // control and parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_zero_count_r <= '0;
      inside_nal_r      <= 1'b0;
      nal_has_bytes_r   <= 1'b0;
      bytes_in_nal_r    <= '0;
      header_value_r    <= '0;
      saturation_seen_r <= 1'b0;
      out_valid_r       <= 1'b0;
      skid_valid_r      <= 1'b0;
    end else begin
      held_zero_count_r <= held_zero_count_nxt;
      inside_nal_r      <= inside_nal_nxt;
      nal_has_bytes_r   <= nal_has_bytes_nxt;
      bytes_in_nal_r    <= bytes_in_nal_nxt;
      header_value_r    <= header_value_nxt;
      saturation_seen_r <= saturation_seen_nxt;
      out_valid_r       <= out_valid_nxt;
      skid_valid_r      <= skid_valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // checks
  `ANX_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r, "skid word without output word")
  `ANX_ASSERT_IMP(a_bytes_need_nal, !inside_nal_r, !nal_has_bytes_r, "nal bytes outside a nal")
  `ANX_ASSERT_IMP(a_payload_nonzero, out_valid_r && out_data_r.kind == KIND_PAYLOAD, out_data_r.payload_byte != 8'd0, "zero payload byte released")
  `ANX_ASSERT_NXT(a_flush_clears, in_fire && in_flush, !inside_nal_r && held_zero_count_r == '0, "flush left parser state")

endmodule

`default_nettype wire

[tb/annexb_nal_unit_splitter_tb.sv]
`timescale 1ns / 1ps
// testbench for the annex-b nal unit splitter: directed table then random nal sequences
// depends on anx_nal_pkg, anx_stream_if and annexb_nal_unit_splitter from rtl

module annexb_nal_unit_splitter_tb;
  import anx_nal_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_WORDS = 1700;
  localparam int IDLE_PERCENT = 38;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 40000;
  localparam logic [15:0] ZERO_RUN_MAX = 16'hffff;
  localparam logic [23:0] UNIT_LEN_MAX = 24'hff_ffff;
  localparam int N_ROWS = 25;

  // one row of the directed table; typed rows carry their own expected word
  typedef struct {
    logic [7:0] stream_byte;
    logic       flush;
    int         reps;
    bit         typed;
    bit         typed_has;
    anx_out_t   typed_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // channel drive, known from time zero
  logic     word_valid = 1'b0;
  anx_in_t  word_data = '0;
  logic     sink_ready = 1'b0;
  bit       idle_on = 1'b1;

  anx_stream_if #(.payload_t(anx_in_t))  in_chan ();
  anx_stream_if #(.payload_t(anx_out_t)) out_chan ();

  assign in_chan.valid   = word_valid;
  assign in_chan.payload = word_data;
  assign out_chan.ready  = sink_ready;

  annexb_nal_unit_splitter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // parser model state
  logic [15:0] zero_run;
  bit          in_unit;
  bit          unit_has_bytes;
  logic [23:0] unit_len;
  logic [7:0]  unit_header;
  bit          sat_seen;

  anx_out_t expected_words[$];
  int mismatches = 0;
  int words_sent = 0;
  int payload_seen = 0;
  int ends_seen = 0;
  int cycle_count = 0;

  stim_row_t directed_rows [N_ROWS] = '{
    // byte outside any nal after reset is dropped
    '{8'h42, 1'b0, 1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 2, 1'b0, 1'b0, '0},
    // start code with nothing open
    '{8'h01, 1'b0, 1, 1'b1, 1'b0, '0},
    '{8'h67, 1'b0, 1, 1'b1, 1'b1,
      '{KIND_PAYLOAD, 8'h67, 16'd0, 1'b1, 5'h07, 6'h33, 24'd1, 1'b0, 1'b0}},
    '{8'hff, 1'b0, 1, 1'b1, 1'b1,
      '{KIND_PAYLOAD, 8'hff, 16'd0, 1'b0, 5'h07, 6'h33, 24'd2, 1'b0, 1'b0}},
    // held zeros released with the next byte
    '{8'h00, 1'b0, 3, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1, 1'b0, 1'b0, '0},
    // trailing zeros before a start code are dropped
    '{8'h00, 1'b0, 2, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1, 1'b1, 1'b1,
      '{KIND_END, 8'h00, 16'd0, 1'b0, 5'h07, 6'h33, 24'd6, 1'b0, 1'b0}},
    // first release carries zeros, so the header is zero
    '{8'h00, 1'b0, 1, 1'b0, 1'b0, '0},
    '{8'h40, 1'b0, 1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1, 1'b1, 1'b1,
      '{KIND_END, 8'h00, 16'd0, 1'b0, 5'h00, 6'h00, 24'd2, 1'b1, 1'b0}},
    // flush with the parser already idle
    '{8'h00, 1'b1, 1, 1'b1, 1'b0, '0},
    // a single zero then 01 is no start code
    '{8'h00, 1'b0, 1, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 2, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1, 1'b0, 1'b0, '0},
    // one-byte nal: hevc type cleared on its end word
    '{8'h01, 1'b0, 1, 1'b1, 1'b1,
      '{KIND_PAYLOAD, 8'h01, 16'd0, 1'b1, 5'h01, 6'h00, 24'd1, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 3, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1, 1'b1, 1'b1,
      '{KIND_END, 8'h00, 16'd0, 1'b0, 5'h01, 6'h00, 24'd1, 1'b0, 1'b0}},
    '{8'hff, 1'b0, 1, 1'b1, 1'b1,
      '{KIND_PAYLOAD, 8'hff, 16'd0, 1'b1, 5'h1f, 6'h3f, 24'd1, 1'b0, 1'b0}},
    // longer zero run held back and released with the next byte
    '{8'h00, 1'b0, 5, 1'b0, 1'b0, '0},
    '{8'h7e, 1'b0, 1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1, 1'b0, 1'b0, '0},
    // byte on a flush word is ignored
    '{8'hff, 1'b1, 1, 1'b1, 1'b0, '0}
  };

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic clear_parser();
    zero_run = '0;
    in_unit = 1'b0;
    unit_has_bytes = 1'b0;
    unit_len = '0;
    unit_header = '0;
    sat_seen = 1'b0;
  endtask

  // end word for the open nal, if it holds any byte
  task automatic close_unit(input bit fin, output bit has, output anx_out_t res);
    has = in_unit && unit_has_bytes;
    res = '0;
    res.kind = KIND_END;
    res.avc_nal_type = unit_header[4:0];
    res.hevc_nal_type = (unit_len > 24'd1) ? unit_header[6:1] : 6'd0;
    res.nal_length = unit_len;
    res.final_nal = fin;
    res.count_saturated = sat_seen;
  endtask

  // per-byte splitting rule: updates the model state, gives at most one word
  task automatic split_word(input anx_in_t w, output bit has, output anx_out_t res);
    logic [31:0] sum;
    has = 1'b0;
    res = '0;
    if (w.flush) begin
      close_unit(1'b1, has, res);
      clear_parser();
    end else if (w.stream_byte == 8'h00) begin
      if (zero_run != ZERO_RUN_MAX) zero_run++;
      if (zero_run == ZERO_RUN_MAX) sat_seen = 1'b1;
    end else if (w.stream_byte == START_MARK && zero_run >= 16'd2) begin
      close_unit(1'b0, has, res);
      clear_parser();
      in_unit = 1'b1;
    end else if (!in_unit) begin
      zero_run = '0;
    end else begin
      if (!unit_has_bytes) unit_header = (zero_run != 0) ? 8'h00 : w.stream_byte;
      sum = 32'(unit_len) + 32'(zero_run) + 32'd1;
      if (sum >= 32'(UNIT_LEN_MAX)) begin
        sum = 32'(UNIT_LEN_MAX);
        sat_seen = 1'b1;
      end
      res.kind = KIND_PAYLOAD;
      res.payload_byte = w.stream_byte;
      res.zeros_before = zero_run;
      res.first_of_nal = !unit_has_bytes;
      res.avc_nal_type = unit_header[4:0];
      res.hevc_nal_type = unit_header[6:1];
      res.nal_length = sum[23:0];
      res.count_saturated = sat_seen;
      unit_len = sum[23:0];
      unit_has_bytes = 1'b1;
      zero_run = '0;
      has = 1'b1;
    end
  endtask

  // hand one word to the block; a typed word replaces the model's expectation
  task automatic send_word(input logic [7:0] b, input logic f, input bit typed = 1'b0,
                           input bit typed_has = 1'b0, input anx_out_t typed_res = '0);
    anx_in_t w;
    bit has;
    anx_out_t res;
    w.stream_byte = b;
    w.flush = f;
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        word_valid <= 1'b0;
        @(posedge clk);
      end
    end
    word_valid <= 1'b1;
    word_data <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    split_word(w, has, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) expected_words.push_back(res);
    words_sent++;
  endtask

  // stream byte biased towards zeros and start code markers
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 8'h00;
    if (r < 30) return START_MARK;
    if (r < 33) return 8'h03;
    return 8'($urandom_range(255));
  endfunction

  // one nal: optional noise, start code, body, and sometimes a flush
  task automatic send_random_unit();
    int n_zeros;
    int n_bytes;
    if ($urandom_range(99) < 8)
      repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(255)), 1'b0);
    // mostly proper start codes, now and then a broken one
    n_zeros = ($urandom_range(99) < 5) ? 1 : $urandom_range(2, 4);
    repeat (n_zeros) send_word(8'h00, 1'b0);
    send_word(START_MARK, 1'b0);
    n_bytes = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 24);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 3) repeat ($urandom_range(20, 300)) send_word(8'h00, 1'b0);
      send_word(pick_byte(), 1'b0);
    end
    if ($urandom_range(99) < 20) send_word(8'($urandom_range(255)), 1'b1);
  endtask

  // sink side: random stalls unless idling is switched off
  always @(posedge clk) begin
    sink_ready <= idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
  end

  // check every result word against the oldest expectation
  always @(posedge clk) begin
    anx_out_t got;
    anx_out_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.payload;
      if (got.kind == KIND_END) ends_seen++;
      else payload_seen++;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word 0x%0h", got));
      end else begin
        want = expected_words.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("payload_byte", got.payload_byte, want.payload_byte);
        check_field("zeros_before", got.zeros_before, want.zeros_before);
        check_field("first_of_nal", got.first_of_nal, want.first_of_nal);
        check_field("avc_nal_type", got.avc_nal_type, want.avc_nal_type);
        check_field("hevc_nal_type", got.hevc_nal_type, want.hevc_nal_type);
        check_field("nal_length", got.nal_length, want.nal_length);
        check_field("final_nal", got.final_nal, want.final_nal);
        check_field("count_saturated", got.count_saturated, want.count_saturated);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_words.size());
      $display("annexb_nal_unit_splitter_tb failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int directed_words;
    clear_parser();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed)
        send_word(directed_rows[i].stream_byte, directed_rows[i].flush, 1'b1,
                  directed_rows[i].typed_has, directed_rows[i].typed_res);
      else
        repeat (directed_rows[i].reps)
          send_word(directed_rows[i].stream_byte, directed_rows[i].flush);
    end
    directed_words = words_sent;

    // random nal sequences, with a stretch of full rate on both sides
    while (words_sent < directed_words + RANDOM_WORDS) begin
      idle_on = !(words_sent >= directed_words + 400 && words_sent < directed_words + 800);
      send_random_unit();
    end
    idle_on = 1'b1;
    send_word(8'($urandom_range(255)), 1'b1);
    word_valid <= 1'b0;

    // drain
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));

    $display("run: %0d words sent, %0d payload words and %0d nal ends checked",
             words_sent, payload_seen, ends_seen);
    $display("%s; %0d mismatches",
             "covered start codes, trailing and held zeros, zero headers, flushes",
             mismatches);
    if (mismatches == 0) begin
      $display("annexb_nal_unit_splitter_tb passed");
    end else begin
      $display("annexb_nal_unit_splitter_tb failed");
    end
    $finish;
  end

endmodule
